// ----- hdl/ppe_pkg.sv -----
`timescale 1ns / 1ps

package ppe_pkg;

  typedef enum logic [1:0] {
    OP_EMIT  = 2'd0,
    OP_TICK  = 2'd1,
    OP_DIRTY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_GRAVITY  = 2'd0,
    REG_SIZE     = 2'd1,
    REG_CAPACITY = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EM_CHECK,
    ST_EM_RNG,
    ST_EM_DIV,
    ST_EM_STORE,
    ST_EM_WRITE,
    ST_TK_CHECK,
    ST_TK_READ,
    ST_TK_PROC,
    ST_TK_END,
    ST_DONE
  } state_e;

  localparam logic [31:0] RNG_SEED       = 32'h1234abcd;
  localparam logic signed [31:0] BOX_LOW_EMPTY  = 32'sh7fffffff;
  localparam logic signed [31:0] BOX_HIGH_EMPTY = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         burst_count;
    logic [6:0]         spread_speed;
    logic [15:0]        lifetime;
  } req_t;

  typedef struct packed {
    logic [6:0]         particle_total;
    logic               box_valid;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_right;
    logic signed [31:0] box_bottom;
  } rsp_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] life;
  } rec_t;

  typedef struct packed {
    logic load_req;
    logic em_start;
    logic rng_step;
    logic div_start;
    logic vel_store;
    logic vel_y;
    logic em_write;
    logic tk_start;
    logic tk_proc;
    logic tk_end;
    logic dirty;
    logic clear;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic em_more;
    logic span_zero;
    logic div_busy;
    logic tk_more;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// ----- hdl/ppe_ctrl.sv -----
`timescale 1ns / 1ps

module ppe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppe_pkg::sts_t sts_i,
  output ppe_pkg::cmd_t cmd_o
);

  ppe_pkg::state_e state_q, state_d;
  logic which_q, which_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppe_pkg::ST_IDLE;
      which_q <= 1'b0;
    end else begin
      state_q <= state_d;
      which_q <= which_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    which_d    = which_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ppe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = ppe_pkg::ST_DECODE;
        end
      end
      ppe_pkg::ST_DECODE: begin
        unique case (sts_i.op)
          ppe_pkg::OP_EMIT: begin
            cmd_o.em_start = 1'b1;
            state_d = ppe_pkg::ST_EM_CHECK;
          end
          ppe_pkg::OP_TICK: begin
            cmd_o.tk_start = 1'b1;
            state_d = ppe_pkg::ST_TK_CHECK;
          end
          ppe_pkg::OP_DIRTY: begin
            cmd_o.dirty = 1'b1;
            state_d = ppe_pkg::ST_DONE;
          end
          default: begin
            cmd_o.clear = 1'b1;
            state_d = ppe_pkg::ST_DONE;
          end
        endcase
      end
      ppe_pkg::ST_EM_CHECK: begin
        which_d = 1'b0;
        state_d = sts_i.em_more ? ppe_pkg::ST_EM_RNG : ppe_pkg::ST_DONE;
      end
      ppe_pkg::ST_EM_RNG: begin
        cmd_o.rng_step  = 1'b1;
        cmd_o.div_start = !sts_i.span_zero;
        state_d = sts_i.span_zero ? ppe_pkg::ST_EM_STORE : ppe_pkg::ST_EM_DIV;
      end
      ppe_pkg::ST_EM_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ppe_pkg::ST_EM_STORE;
        end
      end
      ppe_pkg::ST_EM_STORE: begin
        cmd_o.vel_store = 1'b1;
        cmd_o.vel_y     = which_q;
        which_d = 1'b1;
        state_d = which_q ? ppe_pkg::ST_EM_WRITE : ppe_pkg::ST_EM_RNG;
      end
      ppe_pkg::ST_EM_WRITE: begin
        cmd_o.em_write = 1'b1;
        state_d = ppe_pkg::ST_EM_CHECK;
      end
      ppe_pkg::ST_TK_CHECK: begin
        state_d = sts_i.tk_more ? ppe_pkg::ST_TK_READ : ppe_pkg::ST_TK_END;
      end
      ppe_pkg::ST_TK_READ: begin
        state_d = ppe_pkg::ST_TK_PROC;
      end
      ppe_pkg::ST_TK_PROC: begin
        cmd_o.tk_proc = 1'b1;
        state_d = ppe_pkg::ST_TK_CHECK;
      end
      ppe_pkg::ST_TK_END: begin
        cmd_o.tk_end = 1'b1;
        state_d = ppe_pkg::ST_DONE;
      end
      ppe_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = ppe_pkg::ST_IDLE;
        end
      end
      default: state_d = ppe_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/ppe_dp.sv -----
`timescale 1ns / 1ps

module ppe_dp #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  ppe_pkg::req_t       in_req_i,
  output ppe_pkg::rsp_t       out_rsp_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ppe_pkg::cmd_t       cmd_i,
  output ppe_pkg::sts_t       sts_o
);

  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  logic signed [15:0] gravity_q;
  logic [7:0]         size_q;
  logic [6:0]         cap_q;

  ppe_pkg::req_t      req_q;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [CNT_W-1:0]   i_q;
  logic [IDX_W-1:0]   rd_q;
  logic [7:0]         k_q;
  logic [31:0]        rng_q;
  logic [15:0]        vx_q, vy_q;

  logic [16:0]        rem_q;
  logic [31:0]        num_q;
  logic [4:0]         cnt_q;
  logic               busy_q;

  logic signed [31:0] cur_q  [4];
  logic signed [31:0] prev_q [4];
  logic signed [31:0] tmp_q  [4];

  ppe_pkg::rec_t      mem_q [MAX_PARTICLES];
  ppe_pkg::rec_t      rdata_q;
  ppe_pkg::rec_t      wdata;
  logic [IDX_W-1:0]   waddr;
  logic               we;

  ppe_pkg::rsp_t      out_q;
  logic               out_valid_q;
  logic               res_valid_q;
  logic signed [31:0] res_q [4];

  logic [CMP_W-1:0]   cap_ext, max_ext, live_ext, cap_eff;
  logic [15:0]        span;
  logic [15:0]        divisor;
  logic [31:0]        rng_next;
  logic [16:0]        trial;
  logic [15:0]        vel_new;
  logic [31:0]        nx, ny;
  logic [15:0]        nvy;
  logic signed [31:0] sx, sy, sxe, sye;
  logic               expired;
  logic signed [31:0] un [4];
  logic               un_valid;

  assign cap_ext  = CMP_W'(cap_q);
  assign max_ext  = CMP_W'(MAX_PARTICLES);
  assign live_ext = CMP_W'(live_q);
  assign cap_eff  = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign span     = {1'b0, req_q.spread_speed, 8'd0};
  assign divisor  = {req_q.spread_speed, 8'd0, 1'b1};
  assign rng_next = ppe_pkg::xorshift(rng_q);
  assign trial    = {rem_q[15:0], num_q[31]};
  assign vel_new  = (req_q.spread_speed == 7'd0) ? 16'd0 : rem_q[15:0] - span;

  assign nx      = rdata_q.pos_x + {{16{rdata_q.vel_x[15]}}, rdata_q.vel_x};
  assign ny      = rdata_q.pos_y + {{16{rdata_q.vel_y[15]}}, rdata_q.vel_y};
  assign nvy     = rdata_q.vel_y + gravity_q;
  assign expired = (rdata_q.life == 16'd0);
  assign sx      = $signed(nx) >>> 8;
  assign sy      = $signed(ny) >>> 8;
  assign sxe     = sx + $signed({24'd0, size_q});
  assign sye     = sy + $signed({24'd0, size_q});
  assign live_d  = live_q - CNT_W'(1);

  assign un[0]    = (cur_q[0] < prev_q[0]) ? cur_q[0] : prev_q[0];
  assign un[1]    = (cur_q[1] < prev_q[1]) ? cur_q[1] : prev_q[1];
  assign un[2]    = (cur_q[2] > prev_q[2]) ? cur_q[2] : prev_q[2];
  assign un[3]    = (cur_q[3] > prev_q[3]) ? cur_q[3] : prev_q[3];
  assign un_valid = (un[0] < un[2]) && (un[1] < un[3]);

  assign sts_o.op        = ppe_pkg::op_e'(req_q.operation);
  assign sts_o.em_more   = (k_q < req_q.burst_count) && (live_ext < cap_eff);
  assign sts_o.span_zero = (req_q.spread_speed == 7'd0);
  assign sts_o.div_busy  = busy_q;
  assign sts_o.tk_more   = (i_q < live_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = i_q[IDX_W-1:0];
    wdata = '{pos_x: nx, pos_y: ny, vel_x: rdata_q.vel_x, vel_y: nvy,
              life: rdata_q.life - 16'd1};
    if (cmd_i.em_write) begin
      we    = 1'b1;
      waddr = live_q[IDX_W-1:0];
      wdata = '{pos_x: {{8{req_q.origin_x[15]}}, req_q.origin_x, 8'd0},
                pos_y: {{8{req_q.origin_y[15]}}, req_q.origin_y, 8'd0},
                vel_x: vx_q, vel_y: vy_q, life: req_q.lifetime};
    end else if (cmd_i.tk_proc && !expired) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.vel_store && !cmd_i.vel_y) begin
      vx_q <= vel_new;
    end
    if (cmd_i.vel_store && cmd_i.vel_y) begin
      vy_q <= vel_new;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      num_q <= rng_next;
    end else if (busy_q) begin
      rem_q <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      num_q <= num_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q   <= '0;
      size_q      <= 8'd1;
      cap_q       <= 7'd64;
      live_q      <= '0;
      i_q         <= '0;
      rd_q        <= '0;
      k_q         <= '0;
      rng_q       <= ppe_pkg::RNG_SEED;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      res_valid_q <= 1'b0;
      for (int b = 0; b < 4; b++) begin
        cur_q[b]  <= (b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY;
        prev_q[b] <= (b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY;
        tmp_q[b]  <= (b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY;
        res_q[b]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (ppe_pkg::reg_e'(cfg_index_i))
          ppe_pkg::REG_GRAVITY:  gravity_q <= cfg_data_i;
          ppe_pkg::REG_SIZE:     size_q    <= cfg_data_i[7:0];
          ppe_pkg::REG_CAPACITY: cap_q     <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.load_req) begin
        res_valid_q <= 1'b0;
        for (int b = 0; b < 4; b++) begin
          res_q[b] <= '0;
        end
      end
      if (cmd_i.em_start) begin
        k_q <= '0;
      end
      if (cmd_i.rng_step) begin
        rng_q <= rng_next;
      end
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.em_write) begin
        live_q <= live_q + CNT_W'(1);
        k_q    <= k_q + 8'd1;
      end
      if (cmd_i.tk_start) begin
        i_q  <= '0;
        rd_q <= '0;
        for (int b = 0; b < 4; b++) begin
          tmp_q[b] <= (b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY;
        end
      end
      if (cmd_i.tk_proc) begin
        if (expired) begin
          live_q <= live_d;
          rd_q   <= live_d[IDX_W-1:0];
        end else begin
          i_q  <= i_q + CNT_W'(1);
          rd_q <= IDX_W'(i_q + CNT_W'(1));
          if (sx < tmp_q[0]) tmp_q[0] <= sx;
          if (sy < tmp_q[1]) tmp_q[1] <= sy;
          if (sxe > tmp_q[2]) tmp_q[2] <= sxe;
          if (sye > tmp_q[3]) tmp_q[3] <= sye;
        end
      end
      if (cmd_i.tk_end) begin
        for (int b = 0; b < 4; b++) begin
          prev_q[b] <= cur_q[b];
          cur_q[b]  <= (live_q != '0) ? tmp_q[b] :
                       ((b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY);
        end
      end
      if (cmd_i.dirty) begin
        res_valid_q <= un_valid;
        for (int b = 0; b < 4; b++) begin
          prev_q[b] <= cur_q[b];
          res_q[b]  <= un_valid ? un[b] : 32'sd0;
        end
      end
      if (cmd_i.clear) begin
        live_q <= '0;
        for (int b = 0; b < 4; b++) begin
          prev_q[b] <= cur_q[b];
          cur_q[b]  <= (b < 2) ? ppe_pkg::BOX_LOW_EMPTY : ppe_pkg::BOX_HIGH_EMPTY;
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q          <= 1'b1;
        out_q.particle_total <= 7'(live_q);
        out_q.box_valid      <= res_valid_q;
        out_q.box_left       <= res_q[0];
        out_q.box_top        <= res_q[1];
        out_q.box_right      <= res_q[2];
        out_q.box_bottom     <= res_q[3];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_rsp_o   = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/particle_pool_engine.sv -----
`timescale 1ns / 1ps
// Particle pool engine: up to MAX_PARTICLES particles, with positions in 24.8
// and velocities in 8.8 fixed point. Input channel in_valid_i/in_ready_o
// carries one request (emit, tick, take dirty box, clear); output channel
// out_valid_o/out_ready_i returns exactly one response per request, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 gravity, 1 particle size, 2 capacity); write only while idle.
// One request is in flight at a time; in_ready_o is high only when idle, from
// the cycle after the response is loaded until the next request is accepted.
// Steps from accept to response valid:
//   take dirty / clear: decode, then the final state
//   tick: check, memory read, update per particle live before the tick
//   emit: check, two 32-step serial remainders (x, y), write per particle added;
//     with zero speed, the remainders are skipped
// The response sits in an output register; a stalled receiver holds it and
// the block waits in its final state before going idle.
// Reset clears the live count and the boxes, seeds the random word, loads the
// register defaults and makes the block idle; the particle memory is not
// cleared.
module particle_pool_engine #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppe_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppe_pkg::rsp_t out_rsp_o
);

  ppe_pkg::cmd_t cmd;
  ppe_pkg::sts_t sts;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppe_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .out_rsp_o   (out_rsp_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- hdl/ppe_checker.sv -----
`timescale 1ns / 1ps

module ppe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ppe_pkg::rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response dropped or changed under stall");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while one is in flight");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.box_valid |->
      (out_rsp_o.box_left < out_rsp_o.box_right) &&
      (out_rsp_o.box_top < out_rsp_o.box_bottom))
    else $error("valid box is empty");

  a_box_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.box_valid |->
      (out_rsp_o.box_left == 32'sd0) && (out_rsp_o.box_top == 32'sd0) &&
      (out_rsp_o.box_right == 32'sd0) && (out_rsp_o.box_bottom == 32'sd0))
    else $error("invalid box not zero");

endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
